// ----- design/mfps_pkg.sv -----
// Package for the minimum falling path sum block.
// Holds the sum type, neighbour control struct, saturation limits, configuration width and defaults.
// No dependencies.
package mfps_pkg;

    localparam int SUM_W = 24;
    localparam int CFG_W = 8;
    localparam int DEF_MAX_SIZE = 128;
    localparam int DEF_CELL_BITS = 16;
    localparam int SUM_MAX = 8388607;
    localparam int SUM_MIN = -8388608;

    typedef logic signed [SUM_W-1:0] sum_t;

    typedef struct packed {
        logic first_row;
        logic has_left;
        logic has_right;
    } nbr_ctl_t;

endpackage

// ----- design/mfps_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// The read data register holds its value while no read is issued.
// No dependencies.
module mfps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/mfps_sum.sv -----
// Path sum of one cell: minimum of up to three sums from the row above plus
// the cell value, saturated to the sum range. Depends on mfps_pkg.
module mfps_sum #(
    parameter int CELL_BITS = mfps_pkg::DEF_CELL_BITS
) (
    input  logic signed [CELL_BITS-1:0] cell_val,
    input  mfps_pkg::nbr_ctl_t          ctl,
    input  mfps_pkg::sum_t              up_sum,
    input  mfps_pkg::sum_t              left_sum,
    input  mfps_pkg::sum_t              right_sum,
    output mfps_pkg::sum_t              sum
);
    import mfps_pkg::*;

    localparam int EXT_W = ((CELL_BITS > SUM_W) ? CELL_BITS : SUM_W) + 1;
    localparam logic signed [EXT_W-1:0] HI = EXT_W'(SUM_MAX);
    localparam logic signed [EXT_W-1:0] LO = EXT_W'(SUM_MIN);

    sum_t                    best_lu;
    sum_t                    best;
    logic signed [EXT_W-1:0] total;

    always_comb
    begin
        best_lu = up_sum;
        if (ctl.has_left && (left_sum < best_lu))
        begin
            best_lu = left_sum;
        end
        best = best_lu;
        if (ctl.has_right && (right_sum < best))
        begin
            best = right_sum;
        end
        if (ctl.first_row)
        begin
            total = EXT_W'(cell_val);
        end
        else
        begin
            total = EXT_W'(cell_val) + EXT_W'(best);
        end
        if (total > HI)
        begin
            sum = SUM_W'(SUM_MAX);
        end
        else if (total < LO)
        begin
            sum = SUM_W'(SUM_MIN);
        end
        else
        begin
            sum = SUM_W'(total);
        end
    end

endmodule

// ----- design/min_falling_path_sum.sv -----
// Minimum falling path sum over a square matrix streamed in row-major order.
// Depends on mfps_pkg, mfps_ram and mfps_sum.
//
// One cell transfer is taken every clock cycle, back to back; only the final
// cell of a matrix waits while the previous result is still held unaccepted
// in the result register. The sum of a cell is formed combinationally during its
// transfer and the result of a matrix appears on m_tdata the cycle after its
// final cell. The previous row lives in one RAM with one read and one write
// port; the sum above-right is fetched one cell ahead and a just-written entry
// is forwarded, so the RAM port sets the rate at one cell per cycle for every
// matrix size. A write on the configuration channel sets the size (zero acts
// as one, values above MAX_SIZE act as MAX_SIZE) and restarts the matrix.
module min_falling_path_sum #(
    parameter int MAX_SIZE = mfps_pkg::DEF_MAX_SIZE,
    parameter int CELL_BITS = mfps_pkg::DEF_CELL_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // cell_value in [CELL_BITS-1:0], zero padding above.
    input  logic [((CELL_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // min_sum in [23:0].
    output logic [mfps_pkg::SUM_W-1:0]            m_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mfps_pkg::CFG_W-1:0]            cfg_data
);
    import mfps_pkg::*;

    localparam int CW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;
    logic [CW-1:0] last_reg, last_next;
    sum_t          run_min_reg, run_min_next;
    sum_t          first_sum_reg, first_sum_next;
    sum_t          cur_old_reg, cur_old_next;
    sum_t          left_reg, left_next;
    logic          fwd_reg, fwd_next;
    sum_t          fwd_data_reg, fwd_data_next;
    logic          out_valid_reg, out_valid_next;
    sum_t          out_data_reg, out_data_next;

    logic          accept;
    logic          last_col;
    logic          last_row;
    logic [CW:0]   col_plus2;
    logic          has_two;
    logic [CW-1:0] rd_addr;
    sum_t          ram_rdata;
    sum_t          nxt_val;
    sum_t          cur_val;
    sum_t          sum;
    nbr_ctl_t      ctl;
    logic [CW:0]   cfg_size;

    assign last_col = (col_reg == last_reg);
    assign last_row = (row_reg == last_reg);
    assign s_tready = !(out_valid_reg && !m_tready && last_col && last_row);
    assign accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    assign nxt_val = fwd_reg ? fwd_data_reg : ram_rdata;
    assign cur_val = (col_reg == '0) ? first_sum_reg : cur_old_reg;

    assign ctl.first_row = (row_reg == '0);
    assign ctl.has_left = (col_reg != '0);
    assign ctl.has_right = !last_col;

    assign col_plus2 = {1'b0, col_reg} + (CW + 1)'(2);
    assign has_two = (col_plus2 <= {1'b0, last_reg});

    always_comb
    begin
        if (last_col)
        begin
            rd_addr = (last_reg != '0) ? CW'(1) : '0;
        end
        else if (has_two)
        begin
            rd_addr = col_plus2[CW-1:0];
        end
        else
        begin
            rd_addr = '0;
        end
    end

    mfps_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_SIZE),
        .ADDR_W(CW)
    ) u_row_ram (
        .clk    (clk),
        .wr_en  (accept),
        .wr_addr(col_reg),
        .wr_data(sum),
        .rd_en  (accept),
        .rd_addr(rd_addr),
        .rd_data(ram_rdata)
    );

    mfps_sum #(
        .CELL_BITS(CELL_BITS)
    ) u_sum (
        .cell_val ($signed(s_tdata[CELL_BITS-1:0])),
        .ctl      (ctl),
        .up_sum   (cur_val),
        .left_sum (left_reg),
        .right_sum(nxt_val),
        .sum      (sum)
    );

    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_size = (CW + 1)'(1);
        end
        else if (int'(cfg_data) > MAX_SIZE)
        begin
            cfg_size = (CW + 1)'(MAX_SIZE);
        end
        else
        begin
            cfg_size = (CW + 1)'(cfg_data);
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        last_next = last_reg;
        run_min_next = run_min_reg;
        first_sum_next = first_sum_reg;
        cur_old_next = cur_old_reg;
        left_next = left_reg;
        fwd_next = fwd_reg;
        fwd_data_next = fwd_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next = out_data_reg;

        if (cfg_valid)
        begin
            last_next = CW'(cfg_size - (CW + 1)'(1));
            col_next = '0;
            row_next = '0;
            run_min_next = SUM_W'(SUM_MAX);
        end
        else if (accept)
        begin
            fwd_next = (rd_addr == col_reg);
            fwd_data_next = sum;
            cur_old_next = nxt_val;
            left_next = cur_val;
            if (col_reg == '0)
            begin
                first_sum_next = sum;
            end
            if (last_row && (sum < run_min_reg))
            begin
                run_min_next = sum;
            end
            if (!last_col)
            begin
                col_next = CW'(col_reg + CW'(1));
            end
            else
            begin
                col_next = '0;
                if (!last_row)
                begin
                    row_next = CW'(row_reg + CW'(1));
                end
                else
                begin
                    row_next = '0;
                    run_min_next = SUM_W'(SUM_MAX);
                    out_valid_next = 1'b1;
                    out_data_next = (sum < run_min_reg) ? sum : run_min_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            last_reg <= CW'(MAX_SIZE - 1);
            run_min_reg <= SUM_W'(SUM_MAX);
            fwd_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            last_reg <= last_next;
            run_min_reg <= run_min_next;
            fwd_reg <= fwd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_sum_reg <= first_sum_next;
        cur_old_reg <= cur_old_next;
        left_reg <= left_next;
        fwd_data_reg <= fwd_data_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ----- sim/min_falling_path_sum_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for min_falling_path_sum: streams square matrices of signed
// cells with random gaps and back-pressure and checks every reported minimum path sum.
// Depends on mfps_pkg and the min_falling_path_sum block.
module min_falling_path_sum_test;
    import mfps_pkg::*;

    localparam int MAX_SIZE = DEF_MAX_SIZE;
    localparam int CELL_BITS = DEF_CELL_BITS;
    localparam int CELL_W = ((CELL_BITS + 7) / 8) * 8;
    localparam int RANDOM_CELLS = 680;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES = 8;
    localparam int IDLE_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    typedef enum logic [1:0] {
        ACT_CELL,
        ACT_SIZE,
        ACT_DRAIN
    } act_kind_t;

    typedef struct {
        act_kind_t kind;
        logic [CELL_W-1:0] data;
        int gap;
    } act_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [CELL_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [SUM_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;

    act_t stream_plan[$];
    sum_t min_sum_due[$];

    sum_t path_row[MAX_SIZE];
    sum_t left_above;
    sum_t last_row_min;
    int col_pos;
    int row_pos;
    logic [CFG_W-1:0] size_reg;

    logic hold_armed = 1'b0;
    int hold_left = 0;
    int settle_count = 0;
    int stall_left = 0;
    bit steady_sink = 1'b0;
    int idle_cycles = 0;
    int cells_queued = 0;
    int cells_sent = 0;
    int results_seen = 0;
    int size_writes = 0;
    int mismatches = 0;

    min_falling_path_sum #(
        .MAX_SIZE(MAX_SIZE),
        .CELL_BITS(CELL_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),      // cell_value in [15:0]
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),      // min_sum in [23:0]
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic restart_matrix_model();
        col_pos = 0;
        row_pos = 0;
        left_above = '0;
        last_row_min = sum_t'(SUM_MAX);
    endtask

    task automatic step_path_sum(input logic signed [CELL_BITS-1:0] cell_val);
        int n;
        int c;
        int r;
        longint total;
        sum_t best;
        sum_t sum;
        n = (size_reg == 0) ? 1 : (size_reg > MAX_SIZE) ? MAX_SIZE : int'(size_reg);
        c = (col_pos >= n) ? n - 1 : col_pos;
        r = (row_pos >= n) ? n - 1 : row_pos;
        total = longint'(cell_val);
        if (r > 0)
        begin
            best = path_row[c];
            if (c > 0 && left_above < best)
                best = left_above;
            if (c + 1 < n && path_row[c + 1] < best)
                best = path_row[c + 1];
            total = total + longint'(best);
        end
        if (total > SUM_MAX)
            sum = sum_t'(SUM_MAX);
        else if (total < SUM_MIN)
            sum = sum_t'(SUM_MIN);
        else
            sum = sum_t'(total);
        left_above = path_row[c];
        path_row[c] = sum;
        if (r == n - 1 && sum < last_row_min)
            last_row_min = sum;
        if (c + 1 < n)
            col_pos = c + 1;
        else
        begin
            col_pos = 0;
            if (r + 1 < n)
                row_pos = r + 1;
            else
            begin
                min_sum_due.push_back(last_row_min);
                restart_matrix_model();
            end
        end
    endtask

    function automatic logic [CELL_BITS-1:0] draw_cell();
        case ($urandom_range(0, 7))
            0: return {1'b1, {(CELL_BITS - 1){1'b0}}};
            1: return {1'b0, {(CELL_BITS - 1){1'b1}}};
            default: return CELL_BITS'($urandom);
        endcase
    endfunction

    task automatic queue_cell(input logic [CELL_BITS-1:0] v, input bit burst);
        act_t a;
        a.kind = ACT_CELL;
        a.data = CELL_W'(v);
        a.gap = burst ? 0 : $urandom_range(0, 15);
        stream_plan.push_back(a);
        cells_queued++;
    endtask

    task automatic queue_matrix(input int count, input bit burst);
        for (int i = 0; i < count; i++)
            queue_cell(draw_cell(), burst);
    endtask

    task automatic queue_size(input logic [CFG_W-1:0] v);
        act_t a;
        a.kind = ACT_SIZE;
        a.data = CELL_W'(v);
        a.gap = $urandom_range(0, 15);
        stream_plan.push_back(a);
    endtask

    task automatic queue_drain();
        act_t a;
        a.kind = ACT_DRAIN;
        a.data = '0;
        a.gap = 0;
        stream_plan.push_back(a);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive
        logic cell_busy;
        logic size_busy;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            cfg_valid <= 1'b0;
            cfg_data <= '0;
            hold_armed = 1'b0;
            hold_left = 0;
            settle_count = 0;
        end
        else
        begin
            cell_busy = s_tvalid;
            size_busy = cfg_valid;
            if (s_tvalid && s_tready)
            begin
                step_path_sum(s_tdata[CELL_BITS-1:0]);
                cells_sent++;
                cell_busy = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                size_reg = cfg_data;
                restart_matrix_model();
                size_writes++;
                size_busy = 1'b0;
            end
            if ((s_tvalid && s_tready) || min_sum_due.size() != 0)
                settle_count = 0;
            else if (settle_count < SETTLE_CYCLES)
                settle_count++;
            if (!cell_busy && !size_busy && stream_plan.size() != 0)
            begin
                if (!hold_armed)
                begin
                    hold_left = stream_plan[0].gap;
                    hold_armed = 1'b1;
                end
                if (hold_left > 0)
                    hold_left--;
                else
                begin
                    case (stream_plan[0].kind)
                        ACT_CELL:
                        begin
                            s_tdata <= stream_plan[0].data;
                            cell_busy = 1'b1;
                            void'(stream_plan.pop_front());
                            hold_armed = 1'b0;
                        end
                        ACT_SIZE:
                        begin
                            if (settle_count >= SETTLE_CYCLES)
                            begin
                                cfg_data <= stream_plan[0].data[CFG_W-1:0];
                                size_busy = 1'b1;
                                void'(stream_plan.pop_front());
                                hold_armed = 1'b0;
                            end
                        end
                        ACT_DRAIN:
                        begin
                            if (min_sum_due.size() == 0)
                            begin
                                void'(stream_plan.pop_front());
                                hold_armed = 1'b0;
                            end
                        end
                        default:
                        begin
                            void'(stream_plan.pop_front());
                            hold_armed = 1'b0;
                        end
                    endcase
                end
            end
            s_tvalid <= cell_busy;
            cfg_valid <= size_busy;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : observe
        logic take;
        sum_t due;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            take = m_tready;
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (min_sum_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("min_sum transfer with none expected: got %0d",
                                 $signed(m_tdata));
                end
                else
                begin
                    due = min_sum_due.pop_front();
                    if (m_tdata !== due)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("min_sum mismatch: expected %0d, got %0d",
                                     due, $signed(m_tdata));
                    end
                end
                if ($urandom_range(0, 15) == 0)
                    steady_sink = !steady_sink;
                stall_left = steady_sink ? 0 : $urandom_range(0, 15);
                take = (stall_left == 0);
            end
            else if (!m_tready)
            begin
                if (stall_left > 0)
                    stall_left--;
                take = (stall_left == 0);
            end
            m_tready <= take;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles.", IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin : scenario
        int start_cells;
        int pick;
        int n;
        int side;
        int last_n;
        bit burst;
        bit broken;
        for (int i = 0; i < MAX_SIZE; i++)
            path_row[i] = '0;
        size_reg = CFG_W'(MAX_SIZE);
        restart_matrix_model();

        // Cells at the size left by reset, then a write restarts the matrix.
        queue_cell(16'h7fff, 1'b0);
        queue_cell(16'h8000, 1'b1);
        queue_cell(16'h0000, 1'b0);
        queue_size(8'd1);
        queue_cell(16'h8000, 1'b0);
        queue_cell(16'h7fff, 1'b1);
        queue_size(8'd0);
        queue_cell(16'h0005, 1'b0);
        queue_cell(16'hffff, 1'b0);
        queue_size(8'd2);
        queue_cell(16'h7fff, 1'b1);
        queue_cell(16'h8000, 1'b1);
        queue_cell(16'h8000, 1'b1);
        queue_cell(16'h7fff, 1'b1);
        queue_size(8'd3);
        queue_cell(16'h1234, 1'b0);
        queue_cell(16'hedcb, 1'b0);
        queue_size(8'd3);
        queue_matrix(9, 1'b0);
        queue_drain();

        start_cells = cells_queued;
        last_n = 3;
        broken = 1'b0;
        while (cells_queued < start_cells + RANDOM_CELLS)
        begin
            pick = $urandom_range(0, 19);
            burst = ($urandom_range(0, 4) == 0);
            if (pick < 13)
                n = $urandom_range(1, 6);
            else if (pick < 18)
                n = $urandom_range(7, 16);
            else if (pick == 18)
                n = 0;
            else
                n = $urandom_range(2, 8);
            if (n != last_n || broken || $urandom_range(0, 1) == 1)
                queue_size(CFG_W'(n));
            side = (n == 0) ? 1 : n;
            broken = (pick == 19);
            if (broken)
                queue_matrix($urandom_range(1, side * side - 1), burst);
            else
                queue_matrix(side * side, burst);
            if ($urandom_range(0, 9) == 0)
                queue_drain();
            last_n = n;
        end

        // An oversized write acts as the largest size; two rows, then a restart.
        queue_size(8'd255);
        queue_matrix(2 * MAX_SIZE, 1'b0);
        queue_size(CFG_W'(MAX_SIZE));
        queue_matrix(MAX_SIZE + 2, 1'b1);
        queue_drain();
        queue_size(8'd1);
        queue_matrix(3, 1'b0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (stream_plan.size() != 0 || s_tvalid || cfg_valid || min_sum_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        mismatches = mismatches + min_sum_due.size();

        $display("Run covered %0d cell transfers, %0d matrix results and %0d size writes,",
                 cells_sent, results_seen, size_writes);
        $display("with sizes 0, 1, 128 and 255, restarts inside a matrix, gaps and stalls.");
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
